FILE: hdl/aed_pkg.sv
// aed_pkg: constants, types and arithmetic helpers for audio_echo_delay
// no dependencies

package aed_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned MaxDelay   = 32768;
  localparam int unsigned MaxChans   = 2;
  localparam int unsigned PosW       = $clog2(MaxDelay);
  localparam int unsigned ChanW      = $clog2(MaxChans);
  localparam int unsigned AddrW      = ChanW + PosW;
  localparam int unsigned MemDepth   = MaxChans * MaxDelay;
  localparam int unsigned MemW       = 2 * SampleW;
  localparam int unsigned ProdW      = 2 * SampleW;
  localparam int unsigned ScaledW    = SampleW + 2;
  localparam int unsigned SumW       = ScaledW + 1;
  localparam int unsigned FracBits   = 14;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned ChanCountW = 2;

  localparam logic [CfgIdxW-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DELAY_LENGTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DECAY_GAIN    = 2'd2;

  localparam logic [ChanCountW-1:0]    RST_CHANNEL_COUNT = 2'd1;
  localparam logic [CfgDataW-1:0]      RST_DELAY_LENGTH  = 16'd1;
  localparam logic signed [SampleW-1:0] RST_DECAY_GAIN   = 16'sd8192;

  localparam logic signed [SampleW-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SampleW-1:0] SAMPLE_MAX = 16'sh7fff;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } aed_state_e;

  // q2.14 product scaled back, truncated toward zero
  function automatic logic signed [ScaledW-1:0] scale_q14(input logic signed [ProdW-1:0] p);
    logic signed [ProdW:0] b;
    b = {p[ProdW-1], p} + (p[ProdW-1] ? (ProdW+1)'((1 << FracBits) - 1) : '0);
    return b[FracBits+ScaledW-1:FracBits];
  endfunction

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [SumW-1:0] v);
    logic signed [SampleW-1:0] r;
    if (v < SumW'(SAMPLE_MIN)) begin
      r = SAMPLE_MIN;
    end else if (v > SumW'(SAMPLE_MAX)) begin
      r = SAMPLE_MAX;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/aed_ram.sv
// aed_ram: generic single-write, single-read synchronous ram, read-first
// no dependencies

module aed_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/audio_echo_delay.sv
// audio_echo_delay: per-channel feed-forward and feedback comb echo
// depends on aed_pkg and aed_ram
//
// usage:
//   s_axis carries one signed pcm sample per item in tdata, its channel in tuser.
//   m_axis carries one result per input item: single echo and multi echo.
//   the cfg port writes channel_count, delay_length and decay_gain; the user must
//   write them only while idle, which the block itself does not enforce.
//   each accepted item passes the p1, p2 and output registers to reach m_axis.
// throughput: one item per cycle unless m_axis stalls or an item waits; both delay lines
//   share one 32-bit ram entry per channel and position, read at accept and written
//   back from stage 2. an item whose ram entry is still held by one of the two items in
//   flight waits, so delay_length times channel_count of two or less slows the stream.
// reset: control registers return to their defaults, the position to zero, and a
//   clearing pass zeroes every ram entry, one entry a cycle, with s_axis_tready
//   low; config writes are taken during that pass.
// stall: when m_axis_tready is low the result holds in the output register and
//   up to two more items are still accepted before s_axis_tready drops.

module audio_echo_delay (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [aed_pkg::SampleW-1:0]   s_axis_tdata,   // sample_in
  input  logic [0:0]                    s_axis_tuser,   // channel
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [2*aed_pkg::SampleW-1:0] m_axis_tdata,   // single_echo_out, multi_echo_out
  input  logic                          cfg_we_i,
  input  logic [aed_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [aed_pkg::CfgDataW-1:0]  cfg_data_i
);

  import aed_pkg::*;

  logic [ChanCountW-1:0]     cfg_chans_q;
  logic [CfgDataW-1:0]       cfg_len_q;
  logic signed [SampleW-1:0] cfg_gain_q;

  aed_state_e        state_q, state_d;
  logic [AddrW-1:0]  clr_cnt_q, clr_cnt_d;
  logic              clearing;

  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW:0]     pos_next;
  logic [CfgDataW-1:0] len_eff;
  logic              two_ch;
  logic [ChanW-1:0]  ch_eff;
  logic              frame_last;
  logic [AddrW-1:0]  rd_addr;
  logic              hazard;
  logic              accept;

  logic              p1_v_q, p1_v_d;
  logic [AddrW-1:0]  p1_addr_q;
  logic signed [SampleW-1:0] p1_x_q;

  logic              p2_v_q, p2_v_d;
  logic [AddrW-1:0]  p2_addr_q;
  logic signed [SampleW-1:0] p2_x_q;
  logic signed [ProdW-1:0]   p2_prod_f_q, p2_prod_b_q;

  logic              m_v_q, m_v_d;
  logic [2*SampleW-1:0] m_data_q;

  logic              out_load, p2_move, p1_move;
  logic [MemW-1:0]   ram_rdata;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [MemW-1:0]   ram_wdata;

  logic signed [ProdW-1:0]   prod_f, prod_b;
  logic signed [SumW-1:0]    sum_f, sum_b;
  logic signed [SampleW-1:0] single_res, multi_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_chans_q <= RST_CHANNEL_COUNT;
      cfg_len_q   <= RST_DELAY_LENGTH;
      cfg_gain_q  <= RST_DECAY_GAIN;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CHANNEL_COUNT: cfg_chans_q <= cfg_data_i[ChanCountW-1:0];
        CFG_DELAY_LENGTH:  cfg_len_q   <= cfg_data_i;
        CFG_DECAY_GAIN:    cfg_gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clearing pass state machine
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    clearing  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clearing  = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: ;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // address and position
  always_comb begin
    two_ch     = cfg_chans_q >= ChanCountW'(MaxChans);
    ch_eff     = two_ch ? s_axis_tuser : '0;
    frame_last = !two_ch || (ch_eff == ChanW'(MaxChans - 1));
    if (cfg_len_q == '0) begin
      len_eff = CfgDataW'(1);
    end else if (cfg_len_q > CfgDataW'(MaxDelay)) begin
      len_eff = CfgDataW'(MaxDelay);
    end else begin
      len_eff = cfg_len_q;
    end
    rd_addr  = {ch_eff, pos_q};
    pos_next = {1'b0, pos_q} + 1'b1;
    hazard   = (p1_v_q && (p1_addr_q == rd_addr)) || (p2_v_q && (p2_addr_q == rd_addr));
  end

  assign out_load      = !m_v_q || m_axis_tready;
  assign p2_move       = !p2_v_q || out_load;
  assign p1_move       = !p1_v_q || p2_move;
  assign s_axis_tready = (state_q == ST_RUN) && p1_move && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pos_d = pos_q;
    if (accept && frame_last) begin
      pos_d = (CfgDataW'(pos_next) >= len_eff) ? '0 : pos_next[PosW-1:0];
    end
    p1_v_d = p1_move ? accept : p1_v_q;
    p2_v_d = p2_move ? p1_v_q : p2_v_q;
    m_v_d  = out_load ? p2_v_q : m_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      m_v_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      p1_v_q <= p1_v_d;
      p2_v_q <= p2_v_d;
      m_v_q  <= m_v_d;
    end
  end

  // stage 1: ram data arrives, both products
  assign prod_f = $signed(ram_rdata[SampleW-1:0]) * cfg_gain_q;
  assign prod_b = $signed(ram_rdata[MemW-1:SampleW]) * cfg_gain_q;

  // stage 2: scale, add, saturate, write back
  assign sum_f      = SumW'(p2_x_q) + SumW'(scale_q14(p2_prod_f_q));
  assign sum_b      = SumW'(p2_x_q) + SumW'(scale_q14(p2_prod_b_q));
  assign single_res = sat16(sum_f);
  assign multi_res  = sat16(sum_b);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_addr_q <= rd_addr;
      p1_x_q    <= s_axis_tdata;
    end
    if (p2_move) begin
      p2_addr_q   <= p1_addr_q;
      p2_x_q      <= p1_x_q;
      p2_prod_f_q <= prod_f;
      p2_prod_b_q <= prod_b;
    end
    if (out_load && p2_v_q) begin
      m_data_q <= {multi_res, single_res};
    end
  end

  assign ram_we    = clearing || (p2_v_q && p2_move);
  assign ram_waddr = clearing ? clr_cnt_q : p2_addr_q;
  assign ram_wdata = clearing ? '0 : {multi_res, p2_x_q};

  aed_ram #(
    .WIDTH(MemW),
    .DEPTH(MemDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = m_data_q;

endmodule

FILE: dv/audio_echo_delay_tb.sv
// audio_echo_delay_tb: self-checking bench for the comb echo block, with
// bursty sample traffic, random output stalls and a scoreboard of echo sums
// depends on aed_pkg and the audio_echo_delay rtl

module audio_echo_delay_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aed_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_e;

  class echo_scoreboard;
    bit [ChanCountW-1:0] chan_cfg;
    bit [CfgDataW-1:0] delay_cfg;
    bit signed [SampleW-1:0] gain_cfg;
    bit signed [SampleW-1:0] fwd_line [MaxChans][MaxDelay];
    bit signed [SampleW-1:0] fb_line [MaxChans][MaxDelay];
    int unsigned line_pos;
    bit [2*SampleW-1:0] echo_due [$];
    int errors;

    function new();
      chan_cfg = RST_CHANNEL_COUNT;
      delay_cfg = RST_DELAY_LENGTH;
      gain_cfg = RST_DECAY_GAIN;
      line_pos = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_CHANNEL_COUNT: chan_cfg = val[ChanCountW-1:0];
        CFG_DELAY_LENGTH: delay_cfg = val;
        CFG_DECAY_GAIN: gain_cfg = val;
        default: ;
      endcase
    endfunction

    function int active_chans();
      if (chan_cfg == 0) return 1;
      if (chan_cfg > MaxChans) return MaxChans;
      return int'(chan_cfg);
    endfunction

    function bit signed [SampleW-1:0] clip(int v);
      if (v < -32768) return SAMPLE_MIN;
      if (v > 32767) return SAMPLE_MAX;
      return v[SampleW-1:0];
    endfunction

    function int pending();
      return echo_due.size();
    endfunction

    // echo sums for one accepted sample, then line update and position advance
    function void note_sample(bit signed [SampleW-1:0] sample, bit chan);
      int chans, len, ch, x, g;
      int unsigned p;
      bit signed [SampleW-1:0] single, multi;
      chans = active_chans();
      len = (delay_cfg == 0) ? 1 : ((delay_cfg > MaxDelay) ? MaxDelay : int'(delay_cfg));
      ch = (int'(chan) >= chans) ? chans - 1 : int'(chan);
      p = (line_pos >= MaxDelay) ? 0 : line_pos;
      x = int'(sample);
      g = int'(gain_cfg);
      single = clip(x + (int'(fwd_line[ch][p]) * g) / 16384);
      multi = clip(x + (int'(fb_line[ch][p]) * g) / 16384);
      fwd_line[ch][p] = sample;
      fb_line[ch][p] = multi;
      if (ch == chans - 1) begin
        line_pos = (p + 1 >= len) ? 0 : p + 1;
      end
      echo_due.push_back({multi, single});
    endfunction

    function void check_echo(logic [2*SampleW-1:0] data);
      bit [2*SampleW-1:0] want;
      if (echo_due.size() == 0) begin
        $display("%0t: unexpected echo item, expected none, actual %h", $time, data);
        errors++;
        return;
      end
      want = echo_due.pop_front();
      if (data[SampleW-1:0] !== want[SampleW-1:0]) begin
        $display("%0t: single_echo_out expected %0d actual %0d", $time,
                 $signed(want[SampleW-1:0]), $signed(data[SampleW-1:0]));
        errors++;
      end
      if (data[2*SampleW-1:SampleW] !== want[2*SampleW-1:SampleW]) begin
        $display("%0t: multi_echo_out expected %0d actual %0d", $time,
                 $signed(want[2*SampleW-1:SampleW]), $signed(data[2*SampleW-1:SampleW]));
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [SampleW-1:0] s_axis_tdata = '0;    // sample_in
  logic [0:0] s_axis_tuser = '0;            // channel
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2*SampleW-1:0] m_axis_tdata;       // single_echo_out, multi_echo_out
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  echo_scoreboard sb = new();
  int cycle_cnt = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;

  audio_echo_delay u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CycleLimit);
    $display("FAIL audio_echo_delay");
    $finish;
  end

  // output side: checks accepted items and stalls on its own pattern
  initial begin : receiver
    int hold_left, mode_left, tick;
    rx_mode_e mode;
    hold_left = 0;
    mode_left = 0;
    tick = 0;
    mode = RX_STEADY;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        sb.check_echo(m_axis_tdata);
      end
      tick++;
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        case (mode)
          RX_STEADY: m_axis_tready <= 1'b1;
          RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= (tick % 3 == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic [SampleW-1:0] sample, input bit chan,
                           input bit no_gaps = 1'b0);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= sample;
    s_axis_tuser <= chan;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_sample(sample, chan);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2, 3: return 16'(int'($urandom_range(0, 511)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly in-order channel sequences, some out-of-order noise
  task automatic stream(input int n_items, input bit squeeze);
    int eff;
    bit ch_next, chan;
    eff = sb.active_chans();
    ch_next = 1'b0;
    if (squeeze) hold_req = 1'b1;
    repeat (n_items) begin
      chan = ($urandom_range(0, 7) == 0) ? 1'($urandom_range(0, 1)) : ch_next;
      if (chan == ch_next) ch_next = (eff == 2) ? ~ch_next : 1'b0;
      send_item(pick_sample(), chan, squeeze);
    end
    settle();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: one channel, delay of one frame, gain one half
    send_item(16'h7fff, 1'b0);
    send_item(16'h7fff, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'hffff, 1'b0);
    send_item(16'hfffd, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h0001, 1'b1);
    send_item(16'h5555, 1'b1);
    send_item(16'haaaa, 1'b0);
    send_item(16'h0000, 1'b0);
    settle();

    // two channels, most negative gain
    write_reg(CFG_CHANNEL_COUNT, 16'd2);
    write_reg(CFG_DECAY_GAIN, 16'h8000);
    send_item(16'h8000, 1'b0);
    send_item(16'h8000, 1'b1);
    send_item(16'h8000, 1'b0);
    send_item(16'h7fff, 1'b1);
    send_item(16'h7fff, 1'b0);
    send_item(16'h0001, 1'b1);
    send_item(16'hffff, 1'b0);
    send_item(16'h7ffe, 1'b1);
    send_item(16'h8001, 1'b0);
    send_item(16'h0000, 1'b1);
    send_item(16'h0064, 1'b1);
    send_item(16'h0000, 1'b0);
    settle();

    write_reg(CFG_DELAY_LENGTH, 16'd3);
    write_reg(CFG_DECAY_GAIN, 16'h4000);
    stream(300, 1'b0);

    write_reg(CFG_CHANNEL_COUNT, 16'd0);
    write_reg(CFG_DELAY_LENGTH, 16'd0);
    write_reg(CFG_DECAY_GAIN, 16'h7fff);
    stream(200, 1'b0);

    write_reg(CFG_CHANNEL_COUNT, 16'd3);
    write_reg(CFG_DELAY_LENGTH, 16'hffff);
    write_reg(CFG_DECAY_GAIN, 16'($urandom));
    stream(250, 1'b0);

    // shrink the delay mid-stream, position likely past the new length
    write_reg(CFG_CHANNEL_COUNT, 16'd1);
    write_reg(CFG_DELAY_LENGTH, 16'd37);
    write_reg(CFG_DECAY_GAIN, 16'($urandom));
    stream(300, 1'b0);
    write_reg(CFG_DELAY_LENGTH, 16'd5);
    stream(150, 1'b0);

    write_reg(CFG_CHANNEL_COUNT, 16'd2);
    write_reg(CFG_DELAY_LENGTH, 16'd1);
    write_reg(CFG_DECAY_GAIN, 16'hc000);
    stream(200, 1'b1);

    write_reg(CFG_CHANNEL_COUNT, 16'd1);
    write_reg(CFG_DELAY_LENGTH, 16'd2);
    write_reg(CFG_DECAY_GAIN, 16'($urandom));
    stream(200, 1'b1);

    write_reg(CFG_SPARE, 16'($urandom));
    write_reg(CFG_CHANNEL_COUNT, 16'd2);
    write_reg(CFG_DELAY_LENGTH, 16'd32768);
    write_reg(CFG_DECAY_GAIN, 16'($urandom));
    stream(200, 1'b0);

    write_reg(CFG_CHANNEL_COUNT, 16'd1);
    write_reg(CFG_DELAY_LENGTH, 16'd32767);
    write_reg(CFG_DECAY_GAIN, 16'h8000);
    stream(100, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS audio_echo_delay");
    end else begin
      $display("FAIL audio_echo_delay");
    end
    $finish;
  end

endmodule
